### rtl/fbfa_pkg.sv
package fbfa_pkg;

  // Table geometry
  localparam int NUM_BLOCKS = 16;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int SIZE_W     = 16;

  // Request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_LOADED        = 2'd0;
  localparam logic [1:0] STATUS_ALLOCATED     = 2'd1;
  localparam logic [1:0] STATUS_NOT_ALLOCATED = 2'd2;

  // Fit policies
  localparam logic POLICY_FIRST = 1'b0;
  localparam logic POLICY_BEST  = 1'b1;

  // Register indexes (word address bit 2)
  localparam logic REG_FIT_POLICY    = 1'b0;
  localparam logic REG_ACTIVE_BLOCKS = 1'b1;

  localparam logic [CNT_W-1:0] ACTIVE_RESET = 5'd16;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  load_index;
    logic [SIZE_W-1:0] req_size;
  } fbfa_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  chosen_block;
    logic [SIZE_W-1:0] remaining;
  } fbfa_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } fbfa_state_t;

endpackage

### rtl/first_or_best_fit_allocator_top.sv
// Channel   Ports                               Transfer
// input     start, busy, in_data               beat taken when start=1 and busy=0
// result    out_strobe, out_data               one-cycle beat, cannot be held off
// config    psel, penable, pwrite, paddr,      APB write at access phase;
//           pwdata, prdata, pready             pready is always high
//
// A load beat's result strobes on the next cycle.
// An allocate beat keeps busy high while it scans L entries, L = min(active_blocks, 16),
// and its result strobes in the cycle in which busy falls: the free-size RAM has one read port
// and the scan reads one entry per cycle.
// Synchronous active-low reset clears the control state and the valid bits;
// a block never loaded reads as size zero. The receiver cannot stall results.
module first_or_best_fit_allocator_top
  import fbfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  fbfa_in_t    in_data,
  output logic        out_strobe,
  output fbfa_out_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic             fit_policy_r;
  logic [CNT_W-1:0] active_blocks_r;

  // Control and datapath state
  fbfa_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  lim_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SIZE_W-1:0] size_r;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              cmp_ent_vld_r;
  logic              found_r;
  logic [IDX_W-1:0]  pick_r;
  logic [SIZE_W-1:0] pick_size_r;
  logic              out_strobe_r;
  fbfa_out_t         out_data_r;

  // Free-size RAM and its per-entry valid bits
  logic [SIZE_W-1:0]     mem [NUM_BLOCKS];
  logic [SIZE_W-1:0]     rd_data_r;
  logic [NUM_BLOCKS-1:0] ent_vld_r;

  logic              accept;
  logic              issue;
  logic [SIZE_W-1:0] cur_size;
  logic              take;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [SIZE_W-1:0] wdata;
  logic [SIZE_W-1:0] rem_size;
  logic [CNT_W-1:0]  lim_nxt;
  logic              cfg_wr;

  assign accept   = start && !busy;
  assign busy     = (state_r != ST_IDLE);
  assign issue    = (state_r == ST_SCAN) && (cnt_r < lim_r);
  assign cur_size = cmp_ent_vld_r ? rd_data_r : '0;
  assign rem_size = pick_size_r - size_r;
  assign lim_nxt  = (active_blocks_r > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                           : active_blocks_r;

  // Candidate test: fits, and is first found or strictly smaller under best fit
  assign take = cmp_vld_r && (cur_size >= size_r) &&
                (!found_r || ((fit_policy_r == POLICY_BEST) && (cur_size < pick_size_r)));

  // APB port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_FIT_POLICY:    prdata = {31'b0, fit_policy_r};
      REG_ACTIVE_BLOCKS: prdata = {{(32-CNT_W){1'b0}}, active_blocks_r};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r    <= POLICY_FIRST;
      active_blocks_r <= ACTIVE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FIT_POLICY:    fit_policy_r    <= pwdata[0];
        REG_ACTIVE_BLOCKS: active_blocks_r <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and RAM write port
  always_comb begin
    state_nxt = state_r;
    we        = 1'b0;
    waddr     = in_data.load_index;
    wdata     = in_data.req_size;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_LOAD) begin
            we = 1'b1;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!issue) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        we        = found_r;
        waddr     = pick_r;
        wdata     = rem_size;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // RAM write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[cnt_r[IDX_W-1:0]];
  end

  // Valid bits: an entry reads as zero until loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (we) begin
      ent_vld_r[waddr] <= 1'b1;
    end
  end

  // Scan control: issue one read per cycle, compare in the cycle after each read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
      cnt_r     <= '0;
      lim_r     <= '0;
    end else begin
      if (accept && (in_data.req_type == REQ_ALLOC)) begin
        cnt_r     <= '0;
        lim_r     <= lim_nxt;
        cmp_vld_r <= 1'b0;
        found_r   <= 1'b0;
      end else begin
        cmp_vld_r <= issue;
        if (issue) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (take) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  // Scan payload: request size, read tag, best candidate so far
  always_ff @(posedge clk) begin
    if (accept) begin
      size_r <= in_data.req_size;
    end
    cmp_idx_r     <= cnt_r[IDX_W-1:0];
    cmp_ent_vld_r <= ent_vld_r[cnt_r[IDX_W-1:0]];
    if (take) begin
      pick_r      <= cmp_idx_r;
      pick_size_r <= cur_size;
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (accept && (in_data.req_type == REQ_LOAD)) ||
                      (state_r == ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH) begin
      if (found_r) begin
        out_data_r.status       <= STATUS_ALLOCATED;
        out_data_r.chosen_block <= pick_r;
        out_data_r.remaining    <= rem_size;
      end else begin
        out_data_r.status       <= STATUS_NOT_ALLOCATED;
        out_data_r.chosen_block <= '0;
        out_data_r.remaining    <= '0;
      end
    end else if (accept) begin
      out_data_r.status       <= STATUS_LOADED;
      out_data_r.chosen_block <= in_data.load_index;
      out_data_r.remaining    <= in_data.req_size;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

import fbfa_pkg::*;

// Tracks the free-size table and checks each result beat against it.
class alloc_tracker;
  logic [SIZE_W-1:0] free_sizes [NUM_BLOCKS];
  logic              policy;
  logic [CNT_W-1:0]  active;
  fbfa_out_t         pending [$];
  int                mismatches;

  function new();
    foreach (free_sizes[i]) free_sizes[i] = '0;
    policy     = POLICY_FIRST;
    active     = ACTIVE_RESET;
    mismatches = 0;
  endfunction

  function void set_register(logic idx, logic [31:0] value);
    if (idx == REG_FIT_POLICY) policy = value[0];
    else active = value[CNT_W-1:0];
  endfunction

  // Apply one load or allocation to the table and return its result.
  function fbfa_out_t fit_request(fbfa_in_t item);
    fbfa_out_t res;
    int        span;
    int        pick;
    bit        found;
    res   = '0;
    pick  = 0;
    found = 0;
    if (item.req_type == REQ_LOAD) begin
      free_sizes[item.load_index] = item.req_size;
      res.status       = STATUS_LOADED;
      res.chosen_block = item.load_index;
      res.remaining    = item.req_size;
      return res;
    end
    // Scan at most the whole table; best fit keeps the lowest index on ties
    span = (active > NUM_BLOCKS) ? NUM_BLOCKS : int'(active);
    for (int j = 0; j < span; j++) begin
      if (free_sizes[j] >= item.req_size) begin
        if (!found || (policy == POLICY_BEST && free_sizes[j] < free_sizes[pick])) begin
          if (!found || policy == POLICY_BEST) pick = j;
          found = 1;
        end
      end
    end
    if (!found) begin
      res.status = STATUS_NOT_ALLOCATED;
      return res;
    end
    free_sizes[pick] = free_sizes[pick] - item.req_size;
    res.status       = STATUS_ALLOCATED;
    res.chosen_block = pick[IDX_W-1:0];
    res.remaining    = free_sizes[pick];
    return res;
  endfunction

  function void note_request(fbfa_in_t item);
    pending.push_back(fit_request(item));
  endfunction

  function void check_result(fbfa_out_t got);
    fbfa_out_t want;
    if (pending.size() == 0) begin
      $display("%0t: result with nothing pending: status %0d block %0d remaining %0d",
               $time, got.status, got.chosen_block, got.remaining);
      mismatches++;
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
      mismatches++;
    end
    if (got.chosen_block !== want.chosen_block) begin
      $display("%0t: chosen_block expected %0d got %0d", $time,
               want.chosen_block, got.chosen_block);
      mismatches++;
    end
    if (got.remaining !== want.remaining) begin
      $display("%0t: remaining expected %0d got %0d", $time,
               want.remaining, got.remaining);
      mismatches++;
    end
  endfunction
endclass

module tb;

  localparam int STALL_LIMIT = 4000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  fbfa_in_t    in_data;
  logic        out_strobe;
  fbfa_out_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  alloc_tracker book;
  bit           allow_gaps;
  int           quiet_cycles;

  first_or_best_fit_allocator_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Check result beats and watch for a stalled run
  always @(posedge clk) begin
    if (rst_n && out_strobe) book.check_result(out_data);
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // Offer one beat, hold it until taken, then maybe idle a burst
  task automatic issue_request(logic kind, int idx, int size);
    fbfa_in_t item;
    item.req_type   = kind;
    item.load_index = idx[IDX_W-1:0];
    item.req_size   = size[SIZE_W-1:0];
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    book.note_request(item);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic random_request();
    logic kind;
    int   size;
    kind = ($urandom_range(0, 99) < 35) ? REQ_LOAD : REQ_ALLOC;
    case ($urandom_range(0, 9))
      0:       size = 0;
      1:       size = 65535;
      2, 3:    size = $urandom_range(0, 65535);
      default: size = (kind == REQ_LOAD) ? $urandom_range(0, 65535)
                                         : $urandom_range(1, 4096);
    endcase
    issue_request(kind, $urandom_range(0, NUM_BLOCKS - 1), size);
  endtask

  // Stop offering beats and let every pending result come back
  task automatic drain();
    start <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    book.set_register(idx, value);
  endtask

  initial begin
    logic          rnd_policy [8];
    logic [CNT_W-1:0] rnd_active [8];
    clk          = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    quiet_cycles = 0;
    allow_gaps   = 1'b0;
    book         = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: a zero request fits block zero, anything else fails; then loads and first-fit allocations
    issue_request(REQ_ALLOC, 0, 0);
    issue_request(REQ_ALLOC, 9, 1);
    issue_request(REQ_LOAD, 15, 65535);
    issue_request(REQ_LOAD, 0, 100);
    issue_request(REQ_LOAD, 3, 50);
    issue_request(REQ_LOAD, 7, 50);
    issue_request(REQ_LOAD, 5, 32768);
    issue_request(REQ_ALLOC, 0, 40);
    issue_request(REQ_ALLOC, 0, 65535);
    issue_request(REQ_ALLOC, 15, 0);
    drain();

    // Best fit, including a tie between equal blocks
    write_register(REG_FIT_POLICY, 32'(POLICY_BEST));
    issue_request(REQ_ALLOC, 0, 40);
    issue_request(REQ_ALLOC, 0, 45);
    issue_request(REQ_ALLOC, 0, 0);
    issue_request(REQ_ALLOC, 0, 40000);
    drain();

    // No block scanned at all
    write_register(REG_ACTIVE_BLOCKS, 0);
    issue_request(REQ_ALLOC, 0, 0);
    issue_request(REQ_LOAD, 1, 500);
    drain();

    // Count beyond the table clamps to the whole table
    write_register(REG_ACTIVE_BLOCKS, 31);
    issue_request(REQ_ALLOC, 0, 32768);
    issue_request(REQ_ALLOC, 0, 400);
    drain();

    // One block scanned only
    write_register(REG_ACTIVE_BLOCKS, 1);
    issue_request(REQ_ALLOC, 0, 10);
    issue_request(REQ_ALLOC, 0, 400);
    drain();

    // Random phases over several settings; the last one runs without gaps
    rnd_policy = '{POLICY_FIRST, POLICY_BEST, POLICY_FIRST, POLICY_BEST,
                   POLICY_BEST, POLICY_FIRST, POLICY_BEST, POLICY_FIRST};
    rnd_active = '{5'd16, 5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd16, 5'd16};
    rnd_active[6] = CNT_W'($urandom_range(2, 15));
    for (int p = 0; p < 8; p++) begin
      write_register(REG_FIT_POLICY, 32'(rnd_policy[p]));
      write_register(REG_ACTIVE_BLOCKS, 32'(rnd_active[p]));
      allow_gaps = (p != 7);
      repeat (100) random_request();
      drain();
    end

    repeat (20) @(posedge clk);
    if (book.mismatches == 0 && book.pending.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
